/* rtl/mt_pkg.sv */
// ----------------------------------------------------------------------------
// MT19937 state engine package
// Shared constants, request codes and status codes.
// ----------------------------------------------------------------------------
package mt_pkg;

   localparam int STATE_DEPTH  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int KEY_DEPTH    = 32;

   localparam int STATE_AW = $clog2(STATE_DEPTH);
   localparam int KEY_AW   = $clog2(KEY_DEPTH);

   localparam int KIND_W   = 3;
   localparam int WORD_W   = 32;
   localparam int INDEX_W  = 10;
   localparam int LEN_W    = 6;
   localparam int STATUS_W = 2;

   localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;
   localparam logic [WORD_W-1:0] KEY_SEED   = 32'd19650218;
   localparam logic [WORD_W-1:0] MIX1_MULT  = 32'd1664525;
   localparam logic [WORD_W-1:0] MIX2_MULT  = 32'd1566083941;
   localparam logic [WORD_W-1:0] WORD0_INIT = 32'h8000_0000;
   localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908_B0DF;

   localparam logic [STATE_AW-1:0] LAST_WORD  = STATE_AW'(STATE_DEPTH - 1);
   localparam logic [STATE_AW-1:0] FAR_WRAP   = STATE_AW'(STATE_DEPTH - TWIST_OFFSET);
   localparam logic [STATE_AW-1:0] TWIST_OFS  = STATE_AW'(TWIST_OFFSET);
   localparam logic [STATE_AW-1:0] MIX1_COUNT = STATE_AW'(STATE_DEPTH);
   localparam logic [STATE_AW-1:0] MIX2_COUNT = STATE_AW'(STATE_DEPTH - 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_SEED     = 3'd0,
      KIND_LOAD_KEY = 3'd1,
      KIND_KEY_INIT = 3'd2,
      KIND_TWIST    = 3'd3,
      KIND_READ     = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_RANGE      = 2'd1,
      STATUS_NOT_SEEDED = 2'd2
   } status_type;

   function automatic logic [WORD_W-1:0] fold(input logic [WORD_W-1:0] x);
      fold = x ^ (x >> 30);
   endfunction

endpackage

/* rtl/mt_req_if.sv */
// ----------------------------------------------------------------------------
// MT19937 request channel
// Valid/ready channel carrying one engine request.
// ----------------------------------------------------------------------------
interface mt_req_if import mt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [WORD_W-1:0]   value;
   logic [INDEX_W-1:0]  index;
   logic [LEN_W-1:0]    key_count;

   modport source (output valid, kind, value, index, key_count, input ready);
   modport sink   (input valid, kind, value, index, key_count, output ready);
endinterface

/* rtl/mt_rsp_if.sv */
// ----------------------------------------------------------------------------
// MT19937 response channel
// Valid/ready channel carrying one engine response.
// ----------------------------------------------------------------------------
interface mt_rsp_if import mt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   word;
   logic [STATUS_W-1:0] status;

   modport source (output valid, word, status, input ready);
   modport sink   (input valid, word, status, output ready);
endinterface

/* rtl/mt19937_state_engine_core.sv */
// ----------------------------------------------------------------------------
// MT19937 state engine core
// Holds the 624-word state and runs seeding, key loading, key seeding, twist and reads.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan (sink) takes one request: kind, value, index, key_count.
//   rsp_chan (source) returns exactly one response per request: word and
//   status, in request order.
//   The engine works on one request at a time. Per request kind, from the
//   accepting edge to the loading of the response register:
//     load key word, range or not-seeded errors, unused kinds: straight to done
//     read word: a registered state memory read, then the response
//     seed: word 0 written on accept, then a multiply and a write per word
//     twist: a prime and a load of word 0, then a read and a write per word
//     init by key: seed plus two mixing passes of a read and a write per word
//     and a wrap write each pass, then a final write of word 0
//   The rate is set by the read-modify-write walk over the state memory;
//   the state is kept in two mirrored memories so a twist step reads its
//   two operands in the same cycle.
//   A new request is taken as soon as the engine is idle, even while the
//   previous response still waits; a stalled receiver holds the response
//   and the next result waits inside the engine until the register frees.
//   Reset clears the seeded flag, the state machine and the response valid;
//   memory contents stay undefined until written.
// ----------------------------------------------------------------------------
module mt19937_state_engine_core import mt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mt_req_if.sink    req_chan,
   mt_rsp_if.source  rsp_chan
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_MUL,
      ST_SEED_WR,
      ST_MIX_RD,
      ST_MIX_WR,
      ST_MIX_WRAP,
      ST_MIX_FINAL,
      ST_TW_PRIME,
      ST_TW_LOAD,
      ST_TW_RD,
      ST_TW_WR,
      ST_RD_DATA,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic                 seeded_ff, seeded_in;
   logic                 keyed_ff, keyed_in;
   logic                 pass_ff, pass_in;
   logic [WORD_W-1:0]    prev_ff, prev_in;
   logic [WORD_W-1:0]    mul_ff, mul_in;
   logic [WORD_W-1:0]    cur_ff, cur_in;
   logic [STATE_AW-1:0]  idx_ff, idx_in;
   logic [STATE_AW-1:0]  cnt_ff, cnt_in;
   logic [KEY_AW-1:0]    j_ff, j_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [WORD_W-1:0]    res_word_ff, res_word_in;
   status_type           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_word_ff, rsp_word_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic                 st_wr_en;
   logic [STATE_AW-1:0]  st_wr_addr;
   logic [WORD_W-1:0]    st_wr_data;
   logic [STATE_AW-1:0]  st_rd_addr_a, st_rd_addr_b;
   logic [WORD_W-1:0]    st_rd_data_a, st_rd_data_b;
   logic                 key_wr_en;
   logic [KEY_AW-1:0]    key_rd_addr;
   logic [WORD_W-1:0]    key_rd_data;

   logic [WORD_W-1:0]    mul_k;
   logic [WORD_W-1:0]    mix_word;
   logic [WORD_W-1:0]    y_word;
   logic                 accept;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.word   = rsp_word_ff;
   assign rsp_chan.status = rsp_status_ff;

   assign key_wr_en   = accept && (kind_type'(req_chan.kind) == KIND_LOAD_KEY)
                        && (req_chan.index < INDEX_W'(KEY_DEPTH));
   assign key_rd_addr = j_ff;

   mt_ram #(.WIDTH(WORD_W), .DEPTH(STATE_DEPTH)) u_state_a (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr_a),
      .rd_data (st_rd_data_a)
   );

   mt_ram #(.WIDTH(WORD_W), .DEPTH(STATE_DEPTH)) u_state_b (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr_b),
      .rd_data (st_rd_data_b)
   );

   mt_ram #(.WIDTH(WORD_W), .DEPTH(KEY_DEPTH)) u_key (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (req_chan.index[KEY_AW-1:0]),
      .wr_data (req_chan.value),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   always_comb begin
      if (state_ff == ST_SEED_MUL) begin
         mul_k = SEED_MULT;
      end else if (pass_ff) begin
         mul_k = MIX2_MULT;
      end else begin
         mul_k = MIX1_MULT;
      end
      mul_in = fold(prev_ff) * mul_k;
      if (pass_ff) begin
         mix_word = (st_rd_data_a ^ mul_ff) - WORD_W'(idx_ff);
      end else begin
         mix_word = (st_rd_data_a ^ mul_ff) + key_rd_data + WORD_W'(j_ff);
      end
      y_word = {cur_ff[WORD_W-1], st_rd_data_a[WORD_W-2:0]};
   end

   always_comb begin
      state_in      = state_ff;
      seeded_in     = seeded_ff;
      keyed_in      = keyed_ff;
      pass_in       = pass_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      j_in          = j_ff;
      len_in        = len_ff;
      res_word_in   = res_word_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      st_wr_en      = 1'b0;
      st_wr_addr    = idx_ff;
      st_wr_data    = mix_word;
      st_rd_addr_a  = idx_ff;
      st_rd_addr_b  = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            res_word_in   = '0;
            res_status_in = STATUS_OK;
            st_rd_addr_a  = req_chan.index[STATE_AW-1:0];
            if (accept) begin
               state_in = ST_DONE;
               unique case (kind_type'(req_chan.kind))
                  KIND_SEED: begin
                     st_wr_en   = 1'b1;
                     st_wr_addr = '0;
                     st_wr_data = req_chan.value;
                     prev_in    = req_chan.value;
                     idx_in     = STATE_AW'(1);
                     keyed_in   = 1'b0;
                     state_in   = ST_SEED_MUL;
                  end
                  KIND_LOAD_KEY: begin
                     if (req_chan.index >= INDEX_W'(KEY_DEPTH)) begin
                        res_status_in = STATUS_RANGE;
                     end
                  end
                  KIND_KEY_INIT: begin
                     if (req_chan.key_count == '0 ||
                         req_chan.key_count > LEN_W'(KEY_DEPTH)) begin
                        res_status_in = STATUS_RANGE;
                     end else begin
                        st_wr_en   = 1'b1;
                        st_wr_addr = '0;
                        st_wr_data = KEY_SEED;
                        prev_in    = KEY_SEED;
                        idx_in     = STATE_AW'(1);
                        len_in     = req_chan.key_count;
                        keyed_in   = 1'b1;
                        state_in   = ST_SEED_MUL;
                     end
                  end
                  KIND_TWIST: begin
                     if (!seeded_ff) begin
                        res_status_in = STATUS_NOT_SEEDED;
                     end else begin
                        st_rd_addr_a = '0;
                        idx_in       = '0;
                        state_in     = ST_TW_PRIME;
                     end
                  end
                  KIND_READ: begin
                     if (req_chan.index >= INDEX_W'(STATE_DEPTH)) begin
                        res_status_in = STATUS_RANGE;
                     end else if (!seeded_ff) begin
                        res_status_in = STATUS_NOT_SEEDED;
                     end else begin
                        state_in = ST_RD_DATA;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEED_MUL: begin
            state_in = ST_SEED_WR;
         end
         ST_SEED_WR: begin
            st_wr_en   = 1'b1;
            st_wr_data = mul_ff + WORD_W'(idx_ff);
            prev_in    = st_wr_data;
            if (idx_ff == LAST_WORD) begin
               if (keyed_ff) begin
                  prev_in  = KEY_SEED;
                  idx_in   = STATE_AW'(1);
                  j_in     = '0;
                  cnt_in   = MIX1_COUNT;
                  pass_in  = 1'b0;
                  state_in = ST_MIX_RD;
               end else begin
                  seeded_in = 1'b1;
                  state_in  = ST_DONE;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SEED_MUL;
            end
         end
         ST_MIX_RD: begin
            state_in = ST_MIX_WR;
         end
         ST_MIX_WR: begin
            st_wr_en = 1'b1;
            prev_in  = mix_word;
            cnt_in   = cnt_ff - 1'b1;
            if (LEN_W'(j_ff) + 1'b1 >= len_ff) begin
               j_in = '0;
            end else begin
               j_in = j_ff + 1'b1;
            end
            if (idx_ff == LAST_WORD) begin
               idx_in   = STATE_AW'(1);
               state_in = ST_MIX_WRAP;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (cnt_ff == STATE_AW'(1)) begin
                  state_in = pass_ff ? ST_MIX_FINAL : ST_MIX_RD;
                  pass_in  = 1'b1;
                  cnt_in   = MIX2_COUNT;
               end else begin
                  state_in = ST_MIX_RD;
               end
            end
         end
         ST_MIX_WRAP: begin
            st_wr_en   = 1'b1;
            st_wr_addr = '0;
            st_wr_data = prev_ff;
            state_in   = ST_MIX_RD;
            if (cnt_ff == '0) begin
               state_in = pass_ff ? ST_MIX_FINAL : ST_MIX_RD;
               pass_in  = 1'b1;
               cnt_in   = MIX2_COUNT;
            end
         end
         ST_MIX_FINAL: begin
            st_wr_en   = 1'b1;
            st_wr_addr = '0;
            st_wr_data = WORD0_INIT;
            seeded_in  = 1'b1;
            state_in   = ST_DONE;
         end
         ST_TW_PRIME: begin
            state_in = ST_TW_LOAD;
         end
         ST_TW_LOAD: begin
            cur_in   = st_rd_data_a;
            state_in = ST_TW_RD;
         end
         ST_TW_RD: begin
            st_rd_addr_a = (idx_ff == LAST_WORD) ? '0 : idx_ff + 1'b1;
            st_rd_addr_b = (idx_ff < FAR_WRAP) ? idx_ff + TWIST_OFS : idx_ff - FAR_WRAP;
            state_in     = ST_TW_WR;
         end
         ST_TW_WR: begin
            st_wr_en   = 1'b1;
            st_wr_data = st_rd_data_b ^ (y_word >> 1) ^ (y_word[0] ? MATRIX_A : '0);
            cur_in     = st_rd_data_a;
            if (idx_ff == LAST_WORD) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_TW_RD;
            end
         end
         ST_RD_DATA: begin
            res_word_in = st_rd_data_a;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = res_word_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      keyed_ff      <= keyed_in;
      pass_ff       <= pass_in;
      prev_ff       <= prev_in;
      mul_ff        <= mul_in;
      cur_ff        <= cur_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      j_ff          <= j_in;
      len_ff        <= len_in;
      res_word_ff   <= res_word_in;
      res_status_ff <= res_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_wr_addr_range: assert property (@(posedge clock) disable iff (reset)
      st_wr_en |-> st_wr_addr <= LAST_WORD)
      else $error("state write address out of range");

   a_twist_seeded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TW_RD |-> seeded_ff)
      else $error("twist running on unseeded state");

   a_key_slot_in_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MIX_WR |-> LEN_W'(j_ff) < len_ff)
      else $error("key slot beyond key length");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside done state");

endmodule

/* rtl/mt_ram.sv */
// ----------------------------------------------------------------------------
// MT19937 generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
